@@ rtl/aas_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package aas_pkg;

  // Capacity of the alarm list.
  localparam int unsigned MAX_ALARMS = 16;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned OCNT_W  = 5;

  // Internal widths that follow from the capacity.
  localparam int unsigned COUNT_W = $clog2(MAX_ALARMS + 1);
  localparam int unsigned ADDR_W  = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
  localparam int unsigned CMP_W   = (COUNT_W > INDEX_W) ? COUNT_W : INDEX_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_RAISE     = 2'd0,
    FN_CLEAR     = 2'd1,
    FN_CLEAR_ALL = 2'd2,
    FN_READ      = 2'd3
  } func_t;

endpackage

`default_nettype wire

@@ rtl/aas_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aas_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/active_alarm_set_top.sv @@
// Channel   Ports                                           Handshake
// ------    ----------------------------------------------  ----------------------------
// input     in_func, in_code, in_index                      taken when start && !busy
// result    out_count, out_entry_value, out_entry_valid,     one cycle, marked by out_valid
//           out_dropped
//
// One word is worked at a time; busy falls in the cycle that shows its result, so the
// next word can be taken there.
// Raise and clear scan the stored list through the single registered read port of
// the list memory and one comparator, through S_SCAN_RD and S_SCAN_CMP for each entry
// scanned; a clear then moves each later entry down through S_SHIFT_RD and S_SHIFT_WR.
// Clear-all, a raise of zero and a read past the count give their result straight
// from idle; a valid read passes through S_READ_RD and S_READ_WAIT first.
// Reset empties the list at once (count to zero); the memory itself is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module active_alarm_set_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [aas_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [aas_pkg::CODE_W-1:0]   in_code,
  input  wire logic [aas_pkg::INDEX_W-1:0]  in_index,
  output logic                              out_valid,
  output logic [aas_pkg::OCNT_W-1:0]        out_count,
  output logic [aas_pkg::CODE_W-1:0]        out_entry_value,
  output logic                              out_entry_valid,
  output logic                              out_dropped
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_READ_RD,
    S_READ_WAIT
  } state_t;

  state_t                          state_r,  state_nxt;
  aas_pkg::func_t                  func_r,   func_nxt;
  logic [aas_pkg::CODE_W-1:0]      code_r,   code_nxt;
  logic [aas_pkg::ADDR_W-1:0]      raddr_r,  raddr_nxt;
  logic [aas_pkg::COUNT_W-1:0]     count_r,  count_nxt;
  logic [aas_pkg::COUNT_W-1:0]     ptr_r,    ptr_nxt;
  logic                            ovalid_r, ovalid_nxt;
  logic [aas_pkg::OCNT_W-1:0]      ocount_r, ocount_nxt;
  logic [aas_pkg::CODE_W-1:0]      oval_r,   oval_nxt;
  logic                            oev_r,    oev_nxt;
  logic                            odrop_r,  odrop_nxt;

  logic [aas_pkg::COUNT_W-1:0]     ptr_inc;
  logic                            mem_we;
  logic [aas_pkg::ADDR_W-1:0]      mem_waddr;
  logic [aas_pkg::CODE_W-1:0]      mem_wdata;
  logic [aas_pkg::ADDR_W-1:0]      mem_raddr;
  logic [aas_pkg::CODE_W-1:0]      mem_rdata;
  logic                            code_hit;
  logic                            idx_ok;

  aas_ram #(
    .DEPTH (aas_pkg::MAX_ALARMS),
    .WIDTH (aas_pkg::CODE_W),
    .AW    (aas_pkg::ADDR_W)
  ) u_list (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign ptr_inc   = ptr_r + 1'b1;
  // The shared comparator: every scan step compares one stored entry to the code.
  assign code_hit  = (mem_rdata == code_r);
  assign idx_ok    = (aas_pkg::CMP_W'(in_index) < aas_pkg::CMP_W'(count_r));
  assign mem_raddr = raddr_r;

  always_comb begin
    state_nxt  = state_r;
    func_nxt   = func_r;
    code_nxt   = code_r;
    raddr_nxt  = raddr_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    ovalid_nxt = 1'b0;
    oval_nxt   = oval_r;
    oev_nxt    = oev_r;
    odrop_nxt  = odrop_r;
    mem_we     = 1'b0;
    mem_waddr  = ptr_r[aas_pkg::ADDR_W-1:0];
    mem_wdata  = code_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt  = aas_pkg::func_t'(in_func);
          code_nxt  = in_code;
          ptr_nxt   = '0;
          raddr_nxt = '0;
          oval_nxt  = '0;
          oev_nxt   = 1'b0;
          odrop_nxt = 1'b0;
          case (aas_pkg::func_t'(in_func))
            aas_pkg::FN_RAISE: begin
              if (in_code == '0) begin
                ovalid_nxt = 1'b1;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            aas_pkg::FN_CLEAR: begin
              state_nxt = S_SCAN_RD;
            end
            aas_pkg::FN_CLEAR_ALL: begin
              count_nxt  = '0;
              ovalid_nxt = 1'b1;
            end
            aas_pkg::FN_READ: begin
              if (idx_ok) begin
                raddr_nxt = aas_pkg::ADDR_W'(in_index);
                state_nxt = S_READ_RD;
              end else begin
                ovalid_nxt = 1'b1;
              end
            end
            default: begin
              ovalid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        if (ptr_r == count_r) begin
          // Whole list scanned without a match.
          state_nxt  = S_IDLE;
          ovalid_nxt = 1'b1;
          if (func_r == aas_pkg::FN_RAISE) begin
            if (count_r < aas_pkg::COUNT_W'(aas_pkg::MAX_ALARMS)) begin
              mem_we    = 1'b1;
              mem_waddr = count_r[aas_pkg::ADDR_W-1:0];
              mem_wdata = code_r;
              count_nxt = count_r + 1'b1;
            end else begin
              odrop_nxt = 1'b1;
            end
          end
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (code_hit) begin
          if (func_r == aas_pkg::FN_CLEAR) begin
            state_nxt = S_SHIFT_RD;
            raddr_nxt = ptr_inc[aas_pkg::ADDR_W-1:0];
          end else begin
            state_nxt  = S_IDLE;
            ovalid_nxt = 1'b1;
          end
        end else begin
          ptr_nxt   = ptr_inc;
          raddr_nxt = ptr_inc[aas_pkg::ADDR_W-1:0];
          state_nxt = S_SCAN_RD;
        end
      end

      S_SHIFT_RD: begin
        if (ptr_inc >= count_r) begin
          count_nxt  = count_r - 1'b1;
          state_nxt  = S_IDLE;
          ovalid_nxt = 1'b1;
        end else begin
          state_nxt = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        // Entry ptr+1 has arrived from memory; move it down one place.
        mem_we    = 1'b1;
        mem_waddr = ptr_r[aas_pkg::ADDR_W-1:0];
        mem_wdata = mem_rdata;
        ptr_nxt   = ptr_inc;
        raddr_nxt = aas_pkg::ADDR_W'(ptr_inc + 1'b1);
        state_nxt = S_SHIFT_RD;
      end

      S_READ_RD: begin
        state_nxt = S_READ_WAIT;
      end

      S_READ_WAIT: begin
        oval_nxt   = mem_rdata;
        oev_nxt    = 1'b1;
        state_nxt  = S_IDLE;
        ovalid_nxt = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    ocount_nxt = aas_pkg::OCNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
    func_r   <= func_nxt;
    code_r   <= code_nxt;
    raddr_r  <= raddr_nxt;
    ptr_r    <= ptr_nxt;
    ocount_r <= ocount_nxt;
    oval_r   <= oval_nxt;
    oev_r    <= oev_nxt;
    odrop_r  <= odrop_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ovalid_r;
  assign out_count       = ocount_r;
  assign out_entry_value = oval_r;
  assign out_entry_valid = oev_r;
  assign out_dropped     = odrop_r;

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= aas_pkg::COUNT_W'(aas_pkg::MAX_ALARMS))
    else $error("alarm count exceeds capacity");

  a_result_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result issued while still busy");

  a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !(in_func == aas_pkg::FN_CLEAR_ALL)
     && !(in_func == aas_pkg::FN_RAISE && in_code == '0)
     && !(in_func == aas_pkg::FN_READ && !idx_ok)) |=> busy)
    else $error("accepted word did not start a scan");

  a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped) |-> (count_r == aas_pkg::COUNT_W'(aas_pkg::MAX_ALARMS)))
    else $error("drop flagged while list not full");

endmodule

`default_nettype wire
